/* sv/assert_macros.svh */
// Assertion helpers shared by the battery gauge RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The condition holds at every clock edge outside reset.
`define BG_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When ante holds, cons holds in the same cycle.
`define BG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// When ante holds, cons holds in the next cycle.
`define BG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define BG_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define BG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define BG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* sv/bgsoc_pkg.sv */
package bgsoc_pkg;

  localparam int RAW_W = 12;
  localparam int MV_W  = 15;
  localparam int PCT_W = 8;
  localparam int V_W   = 14;
  localparam int PRD_W = 24;
  localparam int SEG_W = 4;
  localparam int SPAN_W = 7;
  localparam int SPCT_W = 5;
  localparam int PNUM_W = 12;
  localparam int BPCT_W = 7;
  localparam int RATIO_W = 3;
  localparam int CURVE_N = 9;

  // Linear scaling of a raw code: code * FULL_SCALE_MV / CODE_MAX.
  localparam logic [RAW_W-1:0] FULL_SCALE_MV = 12'd3300;
  localparam logic [RAW_W-1:0] CODE_MAX      = 12'd4095;

  localparam logic [V_W-1:0]    V_SAT    = 14'd16383;
  localparam logic [BPCT_W-1:0] PCT_FULL = 7'd100;

  // Configuration register indexes.
  localparam logic CFG_CAL_EN    = 1'b0;
  localparam logic CFG_DIV_RATIO = 1'b1;

  // Discharge curve, highest voltage first.
  localparam logic [RAW_W-1:0] CURVE_MV [0:CURVE_N-1] = '{
    12'd4062, 12'd4000, 12'd3900, 12'd3800, 12'd3700,
    12'd3600, 12'd3500, 12'd3400, 12'd3300
  };
  localparam logic [BPCT_W-1:0] CURVE_PCT [0:CURVE_N-1] = '{
    7'd100, 7'd90, 7'd75, 7'd55, 7'd35, 7'd20, 7'd10, 7'd5, 7'd0
  };

  typedef logic signed [MV_W-1:0]  mv_t;
  typedef logic signed [PCT_W-1:0] pct_t;

  typedef struct packed {
    logic load;
    logic scale;
    logic acc;
    logic avg_start;
    logic empty;
    logic ratio;
    logic seg;
    logic pct_start;
    logic pct_fin;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic burst_end;
    logic count_zero;
    logic div_done;
    logic v_high;
    logic v_low;
    logic out_busy;
  } sts_t;

  // First curve point at or below v; only meaningful strictly inside the curve.
  function automatic logic [SEG_W-1:0] seg_of(input logic [V_W-1:0] v);
    logic [SEG_W-1:0] s;
    s = SEG_W'(CURVE_N - 1);
    for (int i = CURVE_N - 1; i >= 1; i--) begin
      if (v >= V_W'(CURVE_MV[SEG_W'(i)])) begin
        s = SEG_W'(i);
      end
    end
    return s;
  endfunction

  function automatic logic [SPAN_W-1:0] span_mv(input logic [SEG_W-1:0] s);
    logic [RAW_W-1:0] d;
    d = CURVE_MV[s - 1'b1] - CURVE_MV[s];
    return d[SPAN_W-1:0];
  endfunction

  function automatic logic [SPCT_W-1:0] span_pct(input logic [SEG_W-1:0] s);
    logic [BPCT_W-1:0] d;
    d = CURVE_PCT[s - 1'b1] - CURVE_PCT[s];
    return d[SPCT_W-1:0];
  endfunction

endpackage

/* sv/bgsoc_if.sv */
interface bgsoc_in_if;
  import bgsoc_pkg::*;

  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_code;
  logic [RAW_W-1:0] calibrated_mv;
  logic             read_ok;
  logic             calibration_ok;

  modport source (output valid, raw_code, calibrated_mv, read_ok, calibration_ok,
                  input ready);
  modport sink (input valid, raw_code, calibrated_mv, read_ok, calibration_ok,
                output ready);
endinterface

interface bgsoc_out_if;
  import bgsoc_pkg::*;

  logic valid;
  logic ready;
  mv_t  pack_mv;
  pct_t charge_percent;
  logic value_changed;

  modport source (output valid, pack_mv, charge_percent, value_changed,
                  input ready);
  modport sink (input valid, pack_mv, charge_percent, value_changed,
                output ready);
endinterface

/* sv/bgsoc_div.sv */
module bgsoc_div #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   cand;
  logic             fits;

  // Restoring division, one quotient bit per cycle, MSB first.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cand     = {rem_r, quo_r[NUM_W-1]};
    fits     = cand >= {1'b0, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = fits ? DEN_W'(cand - {1'b0, den_r}) : cand[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* sv/bgsoc_dp.sv */
`include "assert_macros.svh"

module bgsoc_dp #(
  parameter int SAMPLES_PER_READING = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  bgsoc_pkg::cmd_t                       cmd,
  output bgsoc_pkg::sts_t                       sts,
  input  logic                                  cal_en,
  input  logic [bgsoc_pkg::RATIO_W-1:0]         div_ratio,
  input  logic [bgsoc_pkg::RAW_W-1:0]           raw_code,
  input  logic [bgsoc_pkg::RAW_W-1:0]           calibrated_mv,
  input  logic                                  read_ok,
  input  logic                                  calibration_ok,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output bgsoc_pkg::mv_t                        out_mv,
  output bgsoc_pkg::pct_t                       out_pct,
  output logic                                  out_changed
);
  import bgsoc_pkg::*;

  // The burst length is held to 1..16 samples.
  localparam int N     = (SAMPLES_PER_READING < 1)  ? 1  :
                         (SAMPLES_PER_READING > 16) ? 16 : SAMPLES_PER_READING;
  localparam int CNT_W = $clog2(N + 1);
  localparam int SUM_W = $clog2(N * 4095 + 1);
  localparam int NUM_W = (SUM_W > PNUM_W) ? SUM_W : PNUM_W;
  localparam int DEN_W = (CNT_W > SPAN_W) ? CNT_W : SPAN_W;

  logic [RAW_W-1:0] raw_r, raw_nxt;
  logic [RAW_W-1:0] cal_r, cal_nxt;
  logic             smp_ok_r, smp_ok_nxt;
  logic             use_cal_r, use_cal_nxt;
  logic [PRD_W-1:0] prod_r, prod_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  mv_t              res_mv_r, res_mv_nxt;
  pct_t             res_pct_r, res_pct_nxt;
  logic [SEG_W-1:0] seg_r, seg_nxt;
  logic             out_valid_r, out_valid_nxt;
  mv_t              out_mv_r, out_mv_nxt;
  pct_t             out_pct_r, out_pct_nxt;
  logic             out_chg_r, out_chg_nxt;
  mv_t              last_mv_r, last_mv_nxt;
  pct_t             last_pct_r, last_pct_nxt;

  logic [RAW_W-1:0]   q0;
  logic [RAW_W:0]     r0;
  logic [RAW_W-1:0]   lin_mv;
  logic [RAW_W-1:0]   sample_mv;
  logic [V_W-1:0]     v;
  logic [SEG_W-1:0]   seg_c;
  logic [SPAN_W-1:0]  seg_dv;
  logic [SPCT_W-1:0]  seg_dp;
  logic [SPAN_W-1:0]  diff;
  logic [PNUM_W-1:0]  pnum;
  logic [MV_W-1:0]    ratio_prod;
  logic [V_W-1:0]     v_sat;
  logic               div_start;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic               div_done;
  logic [NUM_W-1:0]   div_quo;

  // x / 4095 for x = code * 3300 < 2^24: take x >> 12, whose remainder stays below twice
  // the divisor, then correct once.
  always_comb begin
    q0        = prod_r[PRD_W-1:RAW_W];
    r0        = {1'b0, prod_r[RAW_W-1:0]} + {1'b0, q0};
    lin_mv    = q0 + RAW_W'(r0 >= {1'b0, CODE_MAX});
    sample_mv = use_cal_r ? cal_r : lin_mv;
  end

  // Curve segment lookup on the scaled voltage, plus ratio scaling and saturation.
  always_comb begin
    v          = res_mv_r[V_W-1:0];
    seg_c      = seg_of(v);
    seg_dv     = span_mv(seg_c);
    seg_dp     = span_pct(seg_c);
    diff       = SPAN_W'(v - V_W'(CURVE_MV[seg_c]));
    pnum       = PNUM_W'(diff) * PNUM_W'(seg_dp);
    ratio_prod = MV_W'(div_quo[RAW_W-1:0]) * MV_W'(div_ratio);
    v_sat      = (ratio_prod > MV_W'(V_SAT)) ? V_SAT : ratio_prod[V_W-1:0];
  end

  // One divider serves both the burst average and the interpolation step.
  always_comb begin
    div_start = cmd.avg_start | cmd.pct_start;
    div_num   = cmd.avg_start ? NUM_W'(sum_r) : NUM_W'(pnum);
    div_den   = cmd.avg_start ? DEN_W'(cnt_r) : DEN_W'(seg_dv);
  end

  bgsoc_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    raw_nxt       = raw_r;
    cal_nxt       = cal_r;
    smp_ok_nxt    = smp_ok_r;
    use_cal_nxt   = use_cal_r;
    prod_nxt      = prod_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    res_mv_nxt    = res_mv_r;
    res_pct_nxt   = res_pct_r;
    seg_nxt       = seg_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_mv_nxt    = out_mv_r;
    out_pct_nxt   = out_pct_r;
    out_chg_nxt   = out_chg_r;
    last_mv_nxt   = last_mv_r;
    last_pct_nxt  = last_pct_r;

    if (cmd.load) begin
      raw_nxt     = raw_code;
      cal_nxt     = calibrated_mv;
      use_cal_nxt = cal_en;
      smp_ok_nxt  = read_ok & (~cal_en | calibration_ok);
    end
    if (cmd.scale) begin
      prod_nxt = PRD_W'(raw_r) * PRD_W'(FULL_SCALE_MV);
    end
    if (cmd.acc) begin
      if (smp_ok_r) begin
        sum_nxt = sum_r + SUM_W'(sample_mv);
        cnt_nxt = cnt_r + 1'b1;
      end
      if (idx_r != CNT_W'(N - 1)) begin
        idx_nxt = idx_r + 1'b1;
      end
    end
    if (cmd.empty) begin
      res_mv_nxt  = '1;
      res_pct_nxt = '1;
    end
    if (cmd.ratio) begin
      res_mv_nxt = mv_t'({1'b0, v_sat});
    end
    if (cmd.seg) begin
      seg_nxt     = seg_c;
      res_pct_nxt = v >= V_W'(CURVE_MV[0]) ? pct_t'({1'b0, PCT_FULL}) : '0;
    end
    if (cmd.pct_fin) begin
      res_pct_nxt = pct_t'({1'b0, CURVE_PCT[seg_r] + div_quo[BPCT_W-1:0]});
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_mv_nxt    = res_mv_r;
      out_pct_nxt   = res_pct_r;
      out_chg_nxt   = (res_mv_r != last_mv_r) || (res_pct_r != last_pct_r);
      last_mv_nxt   = res_mv_r;
      last_pct_nxt  = res_pct_r;
      idx_nxt       = '0;
      cnt_nxt       = '0;
      sum_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      last_mv_r   <= '0;
      last_pct_r  <= '0;
    end else begin
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      last_mv_r   <= last_mv_nxt;
      last_pct_r  <= last_pct_nxt;
    end
    raw_r     <= raw_nxt;
    cal_r     <= cal_nxt;
    smp_ok_r  <= smp_ok_nxt;
    use_cal_r <= use_cal_nxt;
    prod_r    <= prod_nxt;
    res_mv_r  <= res_mv_nxt;
    res_pct_r <= res_pct_nxt;
    seg_r     <= seg_nxt;
    out_mv_r  <= out_mv_nxt;
    out_pct_r <= out_pct_nxt;
    out_chg_r <= out_chg_nxt;
  end

  always_comb begin
    sts.burst_end  = idx_r == CNT_W'(N - 1);
    sts.count_zero = cnt_r == '0;
    sts.div_done   = div_done;
    sts.v_high     = v >= V_W'(CURVE_MV[0]);
    sts.v_low      = v <= V_W'(CURVE_MV[CURVE_N-1]);
    sts.out_busy   = out_valid_r & ~out_ready;
  end

  assign out_valid   = out_valid_r;
  assign out_mv      = out_mv_r;
  assign out_pct     = out_pct_r;
  assign out_changed = out_chg_r;

  `BG_ASSERT_ALWAYS(a_idx_range, clk, rst_n, idx_r <= CNT_W'(N - 1), "burst index past end")
  `BG_ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, (CNT_W+1)'(cnt_r) <= (CNT_W+1)'(idx_r) + 1'b1, "valid count exceeds samples")
  `BG_ASSERT_NEXT(a_emit_loads, clk, rst_n, cmd.emit, out_valid_r, "emitted result not presented")

endmodule

/* sv/bgsoc_ctrl.sv */
`include "assert_macros.svh"

module bgsoc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bgsoc_pkg::sts_t sts,
  output bgsoc_pkg::cmd_t cmd
);
  import bgsoc_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SCALE    = 3'd1;
  localparam logic [2:0] ST_ACC      = 3'd2;
  localparam logic [2:0] ST_AVG      = 3'd3;
  localparam logic [2:0] ST_AVG_WAIT = 3'd4;
  localparam logic [2:0] ST_SEG      = 3'd5;
  localparam logic [2:0] ST_PCT_WAIT = 3'd6;
  localparam logic [2:0] ST_EMIT     = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.burst_end ? ST_AVG : ST_IDLE;
      end
      ST_AVG: begin
        if (sts.count_zero) begin
          cmd.empty = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          cmd.avg_start = 1'b1;
          state_nxt     = ST_AVG_WAIT;
        end
      end
      ST_AVG_WAIT: begin
        if (sts.div_done) begin
          cmd.ratio = 1'b1;
          state_nxt = ST_SEG;
        end
      end
      ST_SEG: begin
        cmd.seg = 1'b1;
        if (!sts.v_high && !sts.v_low) begin
          cmd.pct_start = 1'b1;
          state_nxt     = ST_PCT_WAIT;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_PCT_WAIT: begin
        if (sts.div_done) begin
          cmd.pct_fin = 1'b1;
          state_nxt   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = state_r == ST_IDLE;

  `BG_ASSERT_NEXT(a_load_scales, clk, rst_n, cmd.load, state_r == ST_SCALE, "accepted beat not scaled")
  `BG_ASSERT_IMPL(a_done_awaited, clk, rst_n, sts.div_done, state_r == ST_AVG_WAIT || state_r == ST_PCT_WAIT, "divider finished unexpectedly")
  `BG_ASSERT_IMPL(a_emit_free, clk, rst_n, cmd.emit, !sts.out_busy, "result overwrote waiting beat")

endmodule

/* sv/battery_gauge_average_and_soc_unit.sv */
// Battery gauge: each input beat is one converter sample; after every
// SAMPLES_PER_READING samples the unit emits one result beat with the average
// battery voltage (scaled by the divider ratio, saturated at 16383 mV), the
// state of charge from a nine-point discharge curve, and a flag telling
// whether either value differs from the previous result. A sample counts
// only when read_ok is set and, with calibration enabled, calibration_ok is
// set too; a burst without a single good sample reports -1 for both values.
// Samples are taken one at a time: an ordinary beat passes through three
// steps (accept, scale by 3300, divide by 4095 and accumulate). The beat
// that closes a burst additionally runs the shared bit-serial divider up to
// twice, once for the average and once for the curve interpolation; the
// divider is as wide as the burst sum, and at least 12 bits.
// A finished result waits in an output register, so a new sample is accepted
// while the previous result has not yet been taken.
module battery_gauge_average_and_soc_unit #(
  parameter int SAMPLES_PER_READING = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  bgsoc_in_if.sink                          in_ch,
  bgsoc_out_if.source                       out_ch,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [bgsoc_pkg::RATIO_W-1:0]     cfg_wdata
);
  import bgsoc_pkg::*;

  // Configuration registers. The user must see that they are only written while the unit
  // is idle, so the datapath can sample them directly; the block itself does not enforce it.
  logic               cal_en_r, cal_en_nxt;
  logic [RATIO_W-1:0] div_ratio_r, div_ratio_nxt;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  always_comb begin
    cal_en_nxt    = cal_en_r;
    div_ratio_nxt = div_ratio_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAL_EN:    cal_en_nxt    = cfg_wdata[0];
        CFG_DIV_RATIO: div_ratio_nxt = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_en_r    <= 1'b0;
      div_ratio_r <= RATIO_W'(2);
    end else begin
      cal_en_r    <= cal_en_nxt;
      div_ratio_r <= div_ratio_nxt;
    end
  end

  // The controller sequences each beat; the datapath holds the sample,
  // the burst accumulators, the shared divider and the output register.
  bgsoc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bgsoc_dp #(
    .SAMPLES_PER_READING (SAMPLES_PER_READING)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cal_en         (cal_en_r),
    .div_ratio      (div_ratio_r),
    .raw_code       (in_ch.raw_code),
    .calibrated_mv  (in_ch.calibrated_mv),
    .read_ok        (in_ch.read_ok),
    .calibration_ok (in_ch.calibration_ok),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_mv         (out_ch.pack_mv),
    .out_pct        (out_ch.charge_percent),
    .out_changed    (out_ch.value_changed)
  );

  assign in_ch.ready = in_ready;

endmodule

/* tb/sv/battery_gauge_scoreboard.sv */
// Watches the sample and reading channels, keeps its own copy of the gauge
// state and registers, and checks every reading beat against the oldest
// predicted reading.
module battery_gauge_scoreboard #(
  parameter int SAMPLES_PER_READING = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bgsoc_in_if                           samples,
  bgsoc_out_if                          readings,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [bgsoc_pkg::RATIO_W-1:0] cfg_wdata,
  output int                            mismatches,
  output int                            readings_owed
);
  import bgsoc_pkg::*;

  localparam int BURST_LEN = (SAMPLES_PER_READING < 1) ? 1 :
                             (SAMPLES_PER_READING > 16) ? 16 : SAMPLES_PER_READING;
  localparam int REPORT_MAX = 10;

  typedef struct {
    mv_t  mv;
    pct_t pct;
    logic changed;
  } gauge_reading_t;

  gauge_reading_t owed_q[$];

  logic               cal_on;
  logic [RATIO_W-1:0] ratio;
  int unsigned        seen_count;
  int unsigned        good_count;
  int unsigned        mv_total;
  int                 prev_pct;
  int                 prev_mv;
  int                 errs = 0;

  // Linear interpolation over the discharge curve, clamped at both ends.
  function automatic int soc_from_mv(input int unsigned v);
    int unsigned dv;
    int unsigned dp;
    if (v >= CURVE_MV[0]) return int'(CURVE_PCT[0]);
    if (v <= CURVE_MV[CURVE_N-1]) return int'(CURVE_PCT[CURVE_N-1]);
    for (int i = 1; i < CURVE_N; i++) begin
      if (v >= CURVE_MV[i]) begin
        dv = int'(CURVE_MV[i-1]) - int'(CURVE_MV[i]);
        dp = int'(CURVE_PCT[i-1]) - int'(CURVE_PCT[i]);
        return int'(CURVE_PCT[i]) + int'(((v - int'(CURVE_MV[i])) * dp) / dv);
      end
    end
    return 0;
  endfunction

  task automatic absorb_sample(input logic [RAW_W-1:0] raw, input logic [RAW_W-1:0] cal,
                               input logic rok, input logic cok);
    int unsigned    v;
    int             mv_i;
    int             pct_i;
    gauge_reading_t r;
    if (rok) begin
      if (cal_on) begin
        if (cok) begin
          mv_total += 32'(cal);
          good_count++;
        end
      end else begin
        mv_total += (int'(raw) * int'(FULL_SCALE_MV)) / int'(CODE_MAX);
        good_count++;
      end
    end
    seen_count++;
    if (seen_count < BURST_LEN) return;

    if (good_count == 0) begin
      mv_i  = -1;
      pct_i = -1;
    end else begin
      v = (mv_total / good_count) * ratio;
      if (v > V_SAT) v = 32'(V_SAT);
      mv_i  = int'(v);
      pct_i = soc_from_mv(v);
    end
    r.changed = (pct_i != prev_pct) || (mv_i != prev_mv);
    prev_pct  = pct_i;
    prev_mv   = mv_i;
    r.mv      = mv_t'(mv_i);
    r.pct     = pct_t'(pct_i);
    owed_q.push_back(r);
    seen_count = 0;
    good_count = 0;
    mv_total   = 0;
  endtask

  task automatic check_reading();
    gauge_reading_t want;
    if (owed_q.size() == 0) begin
      errs++;
      if (errs <= REPORT_MAX)
        $display("reading beat with nothing predicted: mv %0d pct %0d changed %0b",
                 readings.pack_mv, readings.charge_percent, readings.value_changed);
    end else begin
      want = owed_q.pop_front();
      if (readings.pack_mv !== want.mv || readings.charge_percent !== want.pct ||
          readings.value_changed !== want.changed) begin
        errs++;
        if (errs <= REPORT_MAX)
          $display({"reading mismatch: predicted mv %0d pct %0d changed %0b, ",
                    "got mv %0d pct %0d changed %0b"},
                   want.mv, want.pct, want.changed, readings.pack_mv,
                   readings.charge_percent, readings.value_changed);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cal_on     = 1'b0;
      ratio      = RATIO_W'(2);
      seen_count = 0;
      good_count = 0;
      mv_total   = 0;
      prev_pct   = 0;
      prev_mv    = 0;
      owed_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_CAL_EN) cal_on = cfg_wdata[0];
        else ratio = cfg_wdata;
      end
      if (samples.valid && samples.ready)
        absorb_sample(samples.raw_code, samples.calibrated_mv, samples.read_ok,
                      samples.calibration_ok);
      if (readings.valid && readings.ready) check_reading();
    end
    readings_owed <= owed_q.size();
    mismatches    <= errs;
  end

endmodule

/* tb/sv/battery_gauge_average_and_soc_unit_tb.sv */
// Stimulus and verdict for the battery gauge. The scoreboard beside the unit
// does all prediction and comparison; this module only feeds samples, writes
// the two registers between phases and drains the reading channel.
module battery_gauge_average_and_soc_unit_tb;
  import bgsoc_pkg::*;

  localparam int READING_LEN = 8;
  localparam int PHASES      = 14;
  localparam int BURSTS      = 12;
  // The closing beat of a burst runs the divider up to twice;
  // this tail covers it with room to spare.
  localparam int TAIL_CYCLES = 100;
  localparam int LONG_HOLD   = 400;
  localparam int WATCHDOG    = 10_000_000;

  // Divider ratio and calibration switch for each random phase. Ratios 0 and
  // 7 are the extremes; 5 to 7 can saturate the voltage at full-scale samples.
  localparam int PHASE_RATIO [0:PHASES-1] = '{1, 4, 0, 7, 2, 3, 5, 6, 1, 2, 1, 4, 2, 1};
  localparam bit PHASE_CAL   [0:PHASES-1] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0,
                                              1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

  // How the samples of one random burst are shaped.
  typedef enum int {
    SHAPE_NEAR,   // clustered around a voltage in or near the curve
    SHAPE_POINT,  // aims at a curve point
    SHAPE_NOISE,  // every field random
    SHAPE_EMPTY,  // no usable sample at all
    SHAPE_RAIL    // codes at 0 or full scale
  } burst_shape_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic               cfg_index;
  logic [RATIO_W-1:0] cfg_wdata;

  bit idle_en     = 1'b1;
  int hold_asked  = 0;
  int hold_served = 0;

  int fault_total;
  int readings_owed;

  bgsoc_in_if  sample_bus ();
  bgsoc_out_if reading_bus ();

  battery_gauge_average_and_soc_unit #(
    .SAMPLES_PER_READING(READING_LEN)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (sample_bus),
    .out_ch   (reading_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  battery_gauge_scoreboard #(
    .SAMPLES_PER_READING(READING_LEN)
  ) scoreboard (
    .clk          (clk),
    .rst_n        (rst_n),
    .samples      (sample_bus),
    .readings     (reading_bus),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (fault_total),
    .readings_owed(readings_owed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The reading side. It stalls in short random bursts while idling is
  // allowed, and once the stimulus asks for it, it holds off for a long
  // stretch so that the unit fills up and pushes back on the sample channel.
  initial begin : reading_sink
    int stall_left;
    stall_left = 0;
    reading_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        stall_left  = LONG_HOLD;
      end else if (stall_left == 0 && idle_en && rst_n && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 11);
      end
      if (stall_left > 0) begin
        reading_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        reading_bus.ready <= 1'b1;
      end
    end
  end

  // Offers one sample beat and returns at the edge where it was taken. Valid
  // is left high so that a following beat can go out back to back; a random
  // gap lowers it first.
  task automatic send_sample(input logic [RAW_W-1:0] raw, input logic [RAW_W-1:0] cal,
                             input logic rok, input logic cok);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      sample_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    sample_bus.valid          <= 1'b1;
    sample_bus.raw_code       <= raw;
    sample_bus.calibrated_mv  <= cal;
    sample_bus.read_ok        <= rok;
    sample_bus.calibration_ok <= cok;
    do @(posedge clk); while (!sample_bus.ready);
  endtask

  // Lowers valid, waits until every predicted reading has been taken, then
  // lets the unit settle so that a register write finds it idle.
  task automatic wait_for_quiet();
    sample_bus.valid <= 1'b0;
    do @(posedge clk); while (readings_owed != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Writes the calibration switch and then the divider ratio at back-to-back
  // edges; the write enable stays high across them.
  task automatic apply_settings(input bit cal_on, input int ratio);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CAL_EN;
    cfg_wdata <= RATIO_W'(cal_on);
    @(posedge clk);
    cfg_index <= CFG_DIV_RATIO;
    cfg_wdata <= RATIO_W'(ratio);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One full burst of random samples. Most bursts aim at a voltage in and around
  // the curve, taking the divider ratio into account, so that the
  // interpolation is exercised segment by segment.
  task automatic play_burst(input bit cal_on, input int ratio);
    burst_shape_t     shape;
    int               roll;
    int               base;
    int               v;
    int               code;
    logic [SEG_W-1:0] pick;
    logic [RAW_W-1:0] raw;
    logic [RAW_W-1:0] cal;
    logic             rok;
    logic             cok;
    roll = $urandom_range(0, 15);
    if (roll < 10) shape = SHAPE_NEAR;
    else if (roll < 12) shape = SHAPE_POINT;
    else if (roll < 14) shape = SHAPE_NOISE;
    else if (roll < 15) shape = SHAPE_EMPTY;
    else shape = SHAPE_RAIL;

    if (shape == SHAPE_POINT) begin
      pick = SEG_W'($urandom_range(0, CURVE_N - 1));
      base = int'(CURVE_MV[pick]);
    end else begin
      base = $urandom_range(3200, 4150);
    end
    if (ratio > 0) base = base / ratio;
    else base = $urandom_range(0, 4095);
    if (base > 4095) base = 4095;

    for (int k = 0; k < READING_LEN; k++) begin
      raw = RAW_W'($urandom_range(0, 4095));
      cal = RAW_W'($urandom_range(0, 4095));
      rok = 1'b1;
      cok = 1'b1;
      case (shape)
        SHAPE_NOISE: begin
          rok = 1'($urandom_range(0, 1));
          cok = 1'($urandom_range(0, 1));
        end
        SHAPE_EMPTY: begin
          if (cal_on && $urandom_range(0, 1) == 1) cok = 1'b0;
          else rok = 1'b0;
        end
        SHAPE_RAIL: begin
          raw = ($urandom_range(0, 1) == 1) ? '1 : '0;
          cal = ($urandom_range(0, 1) == 1) ? '1 : '0;
          rok = ($urandom_range(0, 3) != 0);
          cok = ($urandom_range(0, 3) != 0);
        end
        default: begin
          v = base;
          if (shape == SHAPE_NEAR) begin
            v   = v + int'($urandom_range(0, 40)) - 20;
            rok = ($urandom_range(0, 15) != 0);
            cok = ($urandom_range(0, 15) != 0);
          end
          if (v < 0) v = 0;
          if (v > 4095) v = 4095;
          code = (v * 4095 + 3299) / 3300;
          if (code > 4095) code = 4095;
          cal = RAW_W'(v);
          raw = RAW_W'(code);
        end
      endcase
      send_sample(raw, cal, rok, cok);
    end
  endtask

  initial begin
    // Every input gets a known value before the first edge.
    rst_n                     <= 1'b0;
    cfg_we                    <= 1'b0;
    cfg_index                 <= CFG_CAL_EN;
    cfg_wdata                 <= '0;
    sample_bus.valid          <= 1'b0;
    sample_bus.raw_code       <= '0;
    sample_bus.calibrated_mv  <= '0;
    sample_bus.read_ok        <= 1'b0;
    sample_bus.calibration_ok <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, at the reset settings first (raw scaling, ratio 2).
    // A burst with no successful read gives -1 for both values, and since the
    // last reported pair starts at zero it also counts as a change.
    for (int k = 0; k < READING_LEN; k++)
      send_sample(RAW_W'($urandom_range(0, 4095)), RAW_W'($urandom_range(0, 4095)),
                  1'b0, k[0]);

    // Raw codes at both rails average to 1650 mV, which the divider doubles
    // to exactly the bottom of the curve. The calibration flag is low on half
    // the beats and must be ignored while calibration is off.
    for (int k = 0; k < READING_LEN; k++)
      send_sample(k[0] ? 12'hFFF : 12'h000, k[0] ? 12'h000 : 12'hFFF, 1'b1, k[1]);
    wait_for_quiet();

    // Calibrated full scale with the largest ratio saturates the voltage;
    // one failed read and one failed calibration drop out of the average.
    apply_settings(1'b1, 7);
    for (int k = 0; k < READING_LEN; k++)
      send_sample(12'h000, 12'hFFF, k != 2, k != 5);
    wait_for_quiet();

    // Random phases, each with its own register settings. The second phase
    // starts with a long hold-off on the reading side, and the last two run
    // without any idling.
    for (int phase = 0; phase < PHASES; phase++) begin
      idle_en = (phase < PHASES - 2);
      apply_settings(PHASE_CAL[phase], PHASE_RATIO[phase]);
      if (phase == 1) hold_asked++;
      for (int b = 0; b < BURSTS; b++)
        play_burst(PHASE_CAL[phase], PHASE_RATIO[phase]);
      wait_for_quiet();
    end

    if (fault_total == 0 && readings_owed == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Ends a run that hangs on a handshake.
  initial begin
    #WATCHDOG;
    $display("FAIL");
    $finish;
  end

endmodule
